// ===== rtl/core/sbsc_pkg.sv =====
package sbsc_pkg;

  localparam int WINDOW_SAMPLES_DEF = 20;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int LANES = 3;
  localparam int OUT_BITS = 12;
  localparam int THR_BITS = 12;
  localparam int LIMIT_BITS = 6;
  localparam int COUNT_BITS = 6;
  localparam int USED_BITS = 5;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [THR_BITS-1:0] THR_RESET = 12'd20;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd5;
  localparam logic [COUNT_BITS-1:0] FAULT_MAX = 6'd63;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic update;
  } lane_ctl_t;

  typedef struct packed {
    logic fault;
    logic [OUT_BITS-1:0] range;
    logic [OUT_BITS-1:0] peak;
    logic [OUT_BITS-1:0] base;
  } lane_t;

  typedef struct packed {
    logic emit;
    logic passed;
    logic [USED_BITS-1:0] samples_used;
    logic [COUNT_BITS-1:0] fault_total;
  } verdict_t;

  typedef struct packed {
    logic passed;
    logic [USED_BITS-1:0] samples_used;
    logic [COUNT_BITS-1:0] fault_total;
    logic [LANES-1:0][OUT_BITS-1:0] range;
    logic [LANES-1:0][OUT_BITS-1:0] peak;
    logic [LANES-1:0][OUT_BITS-1:0] base;
  } result_t;

endpackage

// ===== rtl/core/sbsc_in_if.sv =====
interface sbsc_in_if #(
  parameter int SAMPLE_BITS = sbsc_pkg::SAMPLE_BITS_DEF
);
  logic valid;
  logic ready;
  logic [SAMPLE_BITS-1:0] first_sample;
  logic [SAMPLE_BITS-1:0] second_sample;
  logic [SAMPLE_BITS-1:0] third_sample;

  modport source(output valid, output first_sample, output second_sample,
                 output third_sample, input ready);
  modport sink(input valid, input first_sample, input second_sample,
               input third_sample, output ready);
endinterface

// ===== rtl/core/sbsc_out_if.sv =====
interface sbsc_out_if;
  logic valid;
  logic ready;
  logic passed;
  logic [sbsc_pkg::USED_BITS-1:0] samples_used;
  logic [sbsc_pkg::COUNT_BITS-1:0] fault_total;
  logic [sbsc_pkg::OUT_BITS-1:0] first_range;
  logic [sbsc_pkg::OUT_BITS-1:0] second_range;
  logic [sbsc_pkg::OUT_BITS-1:0] third_range;
  logic [sbsc_pkg::OUT_BITS-1:0] first_peak;
  logic [sbsc_pkg::OUT_BITS-1:0] second_peak;
  logic [sbsc_pkg::OUT_BITS-1:0] third_peak;
  logic [sbsc_pkg::OUT_BITS-1:0] first_base;
  logic [sbsc_pkg::OUT_BITS-1:0] second_base;
  logic [sbsc_pkg::OUT_BITS-1:0] third_base;

  modport source(output valid, output passed, output samples_used, output fault_total,
                 output first_range, output second_range, output third_range,
                 output first_peak, output second_peak, output third_peak,
                 output first_base, output second_base, output third_base,
                 input ready);
  modport sink(input valid, input passed, input samples_used, input fault_total,
               input first_range, input second_range, input third_range,
               input first_peak, input second_peak, input third_peak,
               input first_base, input second_base, input third_base,
               output ready);
endinterface

// ===== rtl/core/sbsc_lane.sv =====
module sbsc_lane #(
  parameter int SAMPLE_BITS = sbsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  sbsc_pkg::lane_ctl_t             ctl,
  input  logic [SAMPLE_BITS-1:0]          sample,
  input  logic [sbsc_pkg::THR_BITS-1:0]   threshold,
  output sbsc_pkg::lane_t                 found
);

  localparam int EXT_BITS = (SAMPLE_BITS > sbsc_pkg::OUT_BITS) ? SAMPLE_BITS
                                                               : sbsc_pkg::OUT_BITS;

  logic [SAMPLE_BITS-1:0] base;
  logic [SAMPLE_BITS:0]   low;
  logic [SAMPLE_BITS-1:0] high;

  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS:0]   low_next;
  logic [SAMPLE_BITS-1:0] high_next;
  logic [SAMPLE_BITS:0]   span;
  logic [EXT_BITS:0]      span_ext;
  logic [EXT_BITS:0]      peak_ext;
  logic [EXT_BITS:0]      base_ext;

  always_comb begin
    diff = (sample > base) ? (sample - base) : (base - sample);
    low_next = ({1'b0, sample} < low) ? {1'b0, sample} : low;
    high_next = (sample > high) ? sample : high;
    span = ({1'b0, high_next} >= low_next) ? ({1'b0, high_next} - low_next)
                                           : '0;
    span_ext = (EXT_BITS + 1)'(span);
    peak_ext = (EXT_BITS + 1)'(high_next);
    base_ext = (EXT_BITS + 1)'(base);
    found.fault = ctl.update && ((EXT_BITS + 1)'(diff) > (EXT_BITS + 1)'(threshold));
    found.range = span_ext[sbsc_pkg::OUT_BITS-1:0];
    found.peak = peak_ext[sbsc_pkg::OUT_BITS-1:0];
    found.base = base_ext[sbsc_pkg::OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base <= sample;
      low <= {1'b1, {SAMPLE_BITS{1'b0}}};
      high <= '0;
    end else if (ctl.update) begin
      low <= low_next;
      high <= high_next;
    end
  end

endmodule

// ===== rtl/core/sbsc_ctrl.sv =====
module sbsc_ctrl #(
  parameter int WINDOW_SAMPLES = sbsc_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [sbsc_pkg::LANES-1:0]        faults,
  input  logic [sbsc_pkg::LIMIT_BITS-1:0]   limit,
  output sbsc_pkg::lane_ctl_t               lane_ctl,
  output sbsc_pkg::verdict_t                verdict
);

  localparam int IDX_BITS = $clog2(WINDOW_SAMPLES + 1);
  localparam int UEXT_BITS = (IDX_BITS > sbsc_pkg::USED_BITS) ? IDX_BITS
                                                              : sbsc_pkg::USED_BITS;
  localparam int HIT_BITS = $clog2(sbsc_pkg::LANES + 1);
  localparam int SUM_BITS = sbsc_pkg::COUNT_BITS + 1;

  logic                              have_baseline;
  logic [IDX_BITS-1:0]               sample_index;
  logic [sbsc_pkg::COUNT_BITS-1:0]   fault_count;

  logic [HIT_BITS-1:0]               hits;
  logic [SUM_BITS-1:0]               sum;
  logic [sbsc_pkg::COUNT_BITS-1:0]   fault_count_next;
  logic [IDX_BITS-1:0]               sample_index_next;
  logic [UEXT_BITS-1:0]              used_ext;
  logic                              failed;

  always_comb begin
    hits = '0;
    for (int i = 0; i < sbsc_pkg::LANES; i++) begin
      hits = hits + HIT_BITS'(faults[i]);
    end
    sum = SUM_BITS'(fault_count) + SUM_BITS'(hits);
    fault_count_next = (sum > SUM_BITS'(sbsc_pkg::FAULT_MAX)) ? sbsc_pkg::FAULT_MAX
                                                             : sum[sbsc_pkg::COUNT_BITS-1:0];
    sample_index_next = (sample_index < IDX_BITS'(WINDOW_SAMPLES))
                        ? (sample_index + IDX_BITS'(1)) : sample_index;
    used_ext = UEXT_BITS'(sample_index_next);
    failed = fault_count_next > limit;

    lane_ctl.load = accept && !have_baseline;
    lane_ctl.update = accept && have_baseline;

    verdict.emit = lane_ctl.update &&
                   (failed || (sample_index_next >= IDX_BITS'(WINDOW_SAMPLES)));
    verdict.passed = !failed;
    verdict.samples_used = used_ext[sbsc_pkg::USED_BITS-1:0];
    verdict.fault_total = fault_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_baseline <= 1'b0;
      sample_index <= '0;
      fault_count <= '0;
    end else if (lane_ctl.load) begin
      have_baseline <= 1'b1;
      sample_index <= '0;
      fault_count <= '0;
    end else if (lane_ctl.update) begin
      sample_index <= sample_index_next;
      fault_count <= fault_count_next;
      if (verdict.emit) begin
        have_baseline <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/sensor_baseline_stability_check_core.sv =====
// Checks the stability of three converter channels over a window of sample sets. The first
// request after reset or after a result sets the baseline; each later request is compared
// with it in three parallel channel lanes, and a merging stage counts faults and decides
// when the window ends. The block takes one request per clock cycle while ready is high.
// A result appears on the output in the cycle after the request that ends its window, or,
// when an earlier result is still waiting there, once that earlier result has been taken.
// A two-entry output buffer lets requests keep flowing while one result waits; input ready
// drops only when both entries are full. There is no memory or clearing pass after reset.
module sensor_baseline_stability_check_core #(
  parameter int WINDOW_SAMPLES = sbsc_pkg::WINDOW_SAMPLES_DEF,
  parameter int SAMPLE_BITS = sbsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  sbsc_in_if.sink                               samples,
  sbsc_out_if.source                            results,
  input  logic                                  cfg_write_en,
  input  logic [sbsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sbsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [sbsc_pkg::THR_BITS-1:0]          deviation_threshold;
  logic [sbsc_pkg::LIMIT_BITS-1:0]        fault_limit;

  logic                                   accept;
  logic [sbsc_pkg::LANES-1:0][SAMPLE_BITS-1:0] lane_sample;
  sbsc_pkg::lane_t [sbsc_pkg::LANES-1:0]  found;
  logic [sbsc_pkg::LANES-1:0]             faults;
  sbsc_pkg::lane_ctl_t                    lane_ctl;
  sbsc_pkg::verdict_t                     verdict;
  sbsc_pkg::result_t                      result_next;

  logic                                   out_valid;
  sbsc_pkg::result_t                      out_data;
  logic                                   skid_valid;
  sbsc_pkg::result_t                      skid_data;
  logic                                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_threshold <= sbsc_pkg::THR_RESET;
      fault_limit <= sbsc_pkg::LIMIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        sbsc_pkg::REG_THRESHOLD: deviation_threshold <= cfg_data[sbsc_pkg::THR_BITS-1:0];
        sbsc_pkg::REG_LIMIT: fault_limit <= cfg_data[sbsc_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = !skid_valid;
  assign accept = samples.valid && samples.ready;
  assign lane_sample[0] = samples.first_sample;
  assign lane_sample[1] = samples.second_sample;
  assign lane_sample[2] = samples.third_sample;

  for (genvar i = 0; i < sbsc_pkg::LANES; i++) begin : g_lane
    sbsc_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk(clk),
      .ctl(lane_ctl),
      .sample(lane_sample[i]),
      .threshold(deviation_threshold),
      .found(found[i])
    );
    assign faults[i] = found[i].fault;
    assign result_next.range[i] = found[i].range;
    assign result_next.peak[i] = found[i].peak;
    assign result_next.base[i] = found[i].base;
  end

  sbsc_ctrl #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .faults(faults),
    .limit(fault_limit),
    .lane_ctl(lane_ctl),
    .verdict(verdict)
  );

  assign result_next.passed = verdict.passed;
  assign result_next.samples_used = verdict.samples_used;
  assign result_next.fault_total = verdict.fault_total;

  assign pop = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && verdict.emit) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept && verdict.emit) begin
      if (out_valid && !pop) begin
        skid_data <= result_next;
      end else begin
        out_data <= result_next;
      end
    end
  end

  assign results.valid = out_valid;
  assign results.passed = out_data.passed;
  assign results.samples_used = out_data.samples_used;
  assign results.fault_total = out_data.fault_total;
  assign results.first_range = out_data.range[0];
  assign results.second_range = out_data.range[1];
  assign results.third_range = out_data.range[2];
  assign results.first_peak = out_data.peak[0];
  assign results.second_peak = out_data.peak[1];
  assign results.third_peak = out_data.peak[2];
  assign results.first_base = out_data.base[0];
  assign results.second_base = out_data.base[1];
  assign results.third_base = out_data.base[2];

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (accept && verdict.emit) |=> results.valid)
    else $error("window result was not presented");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(results.valid && !results.ready))
    else $error("skid entry filled without an output stall");

endmodule
